[rtl/double_ended_stack_allocator_core_defines.svh]
// Assertion macros for the double-ended stack allocator.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef DOUBLE_ENDED_STACK_ALLOCATOR_CORE_DEFINES_SVH
`define DOUBLE_ENDED_STACK_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define DESA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("allocator assertion failed");
`define DESA_ASSERT_NEVER(label, clk, rst_n, cond) \
	`DESA_ASSERT(label, clk, rst_n, !(cond))
`else
`define DESA_ASSERT(label, clk, rst_n, prop)
`define DESA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/desa_pkg.sv]
// Shared types, codes, and widths of the double-ended stack allocator.
// No dependencies.
package desa_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int SUM_BITS    = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;
	localparam int ALIGN_BITS  = 4;
	localparam int AMASK_BITS  = (1 << ALIGN_BITS) - 1;

	localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
	localparam logic [31:0] REGION_SIZE_RESET = 32'd65536;

	typedef enum logic [1:0] {
		REQ_ALLOC_BOTTOM = 2'd0,
		REQ_ALLOC_TOP    = 2'd1,
		REQ_FREE_BOTTOM  = 2'd2,
		REQ_FREE_TOP     = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO     = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic {
		CFG_REGION_BASE = 1'b0,
		CFG_REGION_SIZE = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [31:0]           byte_count;
		logic [ALIGN_BITS-1:0] align_log2;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] address;
		logic [31:0] top_mark;
		logic [31:0] bottom_mark;
	} rsp_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] top;
		logic [OFFSET_BITS-1:0] bottom;
	} marks_t;

	function automatic logic [OFFSET_BITS-1:0] eff_size(input logic [31:0] rs);
		logic [SUM_BITS-1:0] rs_w;
		rs_w = SUM_BITS'(rs);
		if (rs_w > SUM_BITS'(OFS_MAX)) begin
			return OFS_MAX;
		end
		return OFFSET_BITS'(rs_w);
	endfunction

	localparam logic [OFFSET_BITS-1:0] TOP_RESET = eff_size(REGION_SIZE_RESET);

endpackage

[rtl/desa_if.sv]
// Request and result channel interfaces of the allocator.
// Depends on desa_pkg for the field widths.
interface desa_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      req_type;
	logic [31:0]                     byte_count;
	logic [desa_pkg::ALIGN_BITS-1:0] align_log2;

	modport source (output valid, output req_type, output byte_count, output align_log2,
		input ready);
	modport sink (input valid, input req_type, input byte_count, input align_log2,
		output ready);
endinterface

interface desa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] address;
	logic [31:0] top_mark;
	logic [31:0] bottom_mark;

	modport source (output valid, output status, output address, output top_mark,
		output bottom_mark, input ready);
	modport sink (input valid, input status, input address, input top_mark,
		input bottom_mark, output ready);
endinterface

[rtl/desa_engine.sv]
// Single-pass allocate/free evaluation: next marks and the result of one request.
// Depends on desa_pkg.
module desa_engine (
	input  desa_pkg::req_t                    req,
	input  desa_pkg::marks_t                  marks,
	input  logic [63:0]                       region_base,
	input  logic [31:0]                       region_size,
	output desa_pkg::marks_t                  marks_next,
	output desa_pkg::rsp_t                    rsp
);
	localparam int OB = desa_pkg::OFFSET_BITS;
	localparam int SB = desa_pkg::SUM_BITS;

	logic [desa_pkg::AMASK_BITS-1:0] amask;
	logic [SB-1:0] amask_w, top_w, bot_w, size_w;
	logic [SB-1:0] start_b, end_b, diff_t, start_t, room_w;
	logic [OB-1:0] total;
	logic [SB-1:0] start;
	logic          fail_b, fail_t;
	desa_pkg::status_t status;

	always_comb begin
		amask   = desa_pkg::AMASK_BITS'((16'd1 << req.align_log2) - 16'd1);
		amask_w = SB'(amask);
		top_w   = SB'(marks.top);
		bot_w   = SB'(marks.bottom);
		size_w  = SB'(req.byte_count);
		total   = desa_pkg::eff_size(region_size);

		start_b = (bot_w + amask_w) & ~amask_w;
		end_b   = start_b + size_w;
		fail_b  = end_b >= top_w;

		diff_t  = top_w - size_w;
		start_t = diff_t & ~amask_w;
		fail_t  = (size_w > top_w) || (start_t <= bot_w);

		room_w  = SB'(total) - top_w;

		marks_next = marks;
		status     = desa_pkg::ST_OK;
		start      = '0;

		case (desa_pkg::req_kind_t'(req.req_type))
			desa_pkg::REQ_ALLOC_BOTTOM: begin
				if (req.byte_count == 32'd0) begin
					status = desa_pkg::ST_ZERO;
				end else if (fail_b) begin
					status = desa_pkg::ST_OVERFLOW;
				end else begin
					start = start_b;
					marks_next.bottom = OB'(end_b);
				end
			end
			desa_pkg::REQ_ALLOC_TOP: begin
				if (req.byte_count == 32'd0) begin
					status = desa_pkg::ST_ZERO;
				end else if (fail_t) begin
					status = desa_pkg::ST_OVERFLOW;
				end else begin
					start = start_t;
					marks_next.top = OB'(start_t);
				end
			end
			desa_pkg::REQ_FREE_BOTTOM: begin
				if (size_w > bot_w) begin
					marks_next.bottom = '0;
				end else begin
					marks_next.bottom = OB'(bot_w - size_w);
				end
			end
			desa_pkg::REQ_FREE_TOP: begin
				if ((top_w >= SB'(total)) || (size_w > room_w)) begin
					marks_next.top = total;
				end else begin
					marks_next.top = OB'(top_w + size_w);
				end
			end
			default: begin
				marks_next = marks;
			end
		endcase

		rsp.status      = status;
		rsp.address     = (status == desa_pkg::ST_OK && start != '0) ||
			(status == desa_pkg::ST_OK && (req.req_type == desa_pkg::REQ_ALLOC_BOTTOM ||
			req.req_type == desa_pkg::REQ_ALLOC_TOP)) ? region_base + 64'(start) : 64'd0;
		rsp.top_mark    = 32'(marks_next.top);
		rsp.bottom_mark = 32'(marks_next.bottom);
	end

endmodule

[rtl/double_ended_stack_allocator_core.sv]
// Top level of the double-ended stack allocator: handshake, registers, marks.
// Depends on desa_pkg, desa_if.sv, desa_engine.sv and the defines header.
//
// One region is allocated from both ends; each request allocates or frees at the
// bottom or the top mark and returns a status, the granted address and both marks.
// A request is taken into an input register; its result is registered in the output
// register. One request is accepted every cycle while results are taken: the mark
// update is a single add, mask and compare pass between the input register and the
// mark registers. Both stages hold while the result is not taken. Writing region_size
// resets the top mark to it and the bottom mark to zero; configuration must be written
// only while the block is idle, which the block itself does not enforce.
`include "double_ended_stack_allocator_core_defines.svh"

module double_ended_stack_allocator_core (
	input  logic               clk,
	input  logic               arst_n,
	desa_req_if.sink           req,
	desa_rsp_if.source         rsp,
	input  logic               cfg_we,
	input  desa_pkg::cfg_index_t cfg_index,
	input  logic [63:0]        cfg_data
);
	desa_pkg::req_t   req_s1;
	logic             valid_s1;
	desa_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;
	desa_pkg::marks_t marks_q;
	desa_pkg::marks_t marks_next;
	desa_pkg::rsp_t   rsp_next;
	logic [63:0]      region_base_q;
	logic [31:0]      region_size_q;
	logic             out_adv;
	logic             s1_adv;

	assign out_adv   = !rsp_valid_q || rsp.ready;
	assign s1_adv    = valid_s1 && out_adv;
	assign req.ready = !valid_s1 || out_adv;

	desa_engine u_engine (
		.req         (req_s1),
		.marks       (marks_q),
		.region_base (region_base_q),
		.region_size (region_size_q),
		.marks_next  (marks_next),
		.rsp         (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1.req_type   <= req.req_type;
			req_s1.byte_count <= req.byte_count;
			req_s1.align_log2 <= req.align_log2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q  <= 64'd0;
			region_size_q  <= desa_pkg::REGION_SIZE_RESET;
			marks_q.top    <= desa_pkg::TOP_RESET;
			marks_q.bottom <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				desa_pkg::CFG_REGION_BASE: begin
					region_base_q <= cfg_data;
				end
				desa_pkg::CFG_REGION_SIZE: begin
					region_size_q  <= cfg_data[31:0];
					marks_q.top    <= desa_pkg::eff_size(cfg_data[31:0]);
					marks_q.bottom <= '0;
				end
				default: begin
					region_base_q <= region_base_q;
				end
			endcase
		end else if (s1_adv) begin
			marks_q <= marks_next;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.address     = rsp_q.address;
	assign rsp.top_mark    = rsp_q.top_mark;
	assign rsp.bottom_mark = rsp_q.bottom_mark;

	`DESA_ASSERT(a_marks_ordered, clk, arst_n, marks_q.bottom <= marks_q.top)
	`DESA_ASSERT(a_top_in_region, clk, arst_n,
		marks_q.top <= desa_pkg::eff_size(region_size_q))
	`DESA_ASSERT(a_fail_keeps_marks, clk, arst_n,
		(s1_adv && !cfg_we && rsp_next.status != desa_pkg::ST_OK) |=>
		($stable(marks_q.top) && $stable(marks_q.bottom)))
	`DESA_ASSERT(a_fail_no_address, clk, arst_n,
		(rsp_valid_q && rsp_q.status != desa_pkg::ST_OK) |-> (rsp_q.address == 64'd0))
	`DESA_ASSERT_NEVER(a_s1_not_lost, clk, arst_n,
		valid_s1 && !out_adv && req.ready)

endmodule

[sim/double_ended_stack_allocator_core_test.sv]
// Self-checking test of double_ended_stack_allocator_core: directed and random requests,
// random stalls on both channels, region reprogramming between idle phases.
// Depends on desa_pkg, desa_if.sv and the RTL of the allocator.
module double_ended_stack_allocator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 1000;
	localparam int LONG_HOLD   = 150;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	desa_pkg::cfg_index_t  cfg_index;
	logic [63:0]           cfg_data;

	desa_req_if req_ch();
	desa_rsp_if rsp_ch();

	double_ended_stack_allocator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch.sink),
		.rsp       (rsp_ch.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [63:0]                      base_addr;
	logic [31:0]                      region_bytes;
	logic [desa_pkg::OFFSET_BITS-1:0] top_ofs;
	logic [desa_pkg::OFFSET_BITS-1:0] bottom_ofs;

	desa_pkg::req_t request_q[$];
	desa_pkg::rsp_t grant_q[$];

	int  issued;
	int  accepted;
	int  mismatches;
	int  stuck;
	int  send_wait;
	int  rsp_wait;
	int  long_hold;
	bit  send_idle;
	bit  recv_idle;
	bit  hold_request;
	bit  req_acc;
	bit  rsp_acc;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic desa_pkg::rsp_t next_grant(desa_pkg::req_t r);
		desa_pkg::rsp_t                   g;
		logic [63:0]                      amask;
		logic [63:0]                      start;
		logic [63:0]                      fin;
		logic [63:0]                      count;
		logic [desa_pkg::OFFSET_BITS-1:0] total;
		total     = desa_pkg::OFFSET_BITS'(region_bytes);
		count     = 64'(r.byte_count);
		amask     = (64'd1 << r.align_log2) - 64'd1;
		g.status  = desa_pkg::ST_OK;
		g.address = '0;
		case (desa_pkg::req_kind_t'(r.req_type))
			desa_pkg::REQ_ALLOC_BOTTOM: begin
				if (count == 0) begin
					g.status = desa_pkg::ST_ZERO;
				end else begin
					start = (64'(bottom_ofs) + amask) & ~amask;
					fin   = start + count;
					if (fin >= 64'(top_ofs)) begin
						g.status = desa_pkg::ST_OVERFLOW;
					end else begin
						bottom_ofs = fin[desa_pkg::OFFSET_BITS-1:0];
						g.address  = base_addr + start;
					end
				end
			end
			desa_pkg::REQ_ALLOC_TOP: begin
				if (count == 0) begin
					g.status = desa_pkg::ST_ZERO;
				end else if (count > 64'(top_ofs)) begin
					g.status = desa_pkg::ST_OVERFLOW;
				end else begin
					start = (64'(top_ofs) - count) & ~amask;
					if (start <= 64'(bottom_ofs)) begin
						g.status = desa_pkg::ST_OVERFLOW;
					end else begin
						top_ofs   = start[desa_pkg::OFFSET_BITS-1:0];
						g.address = base_addr + start;
					end
				end
			end
			desa_pkg::REQ_FREE_BOTTOM: begin
				if (count > 64'(bottom_ofs)) begin
					bottom_ofs = '0;
				end else begin
					bottom_ofs = bottom_ofs - count[desa_pkg::OFFSET_BITS-1:0];
				end
			end
			default: begin
				if (top_ofs >= total || count > 64'(total - top_ofs)) begin
					top_ofs = total;
				end else begin
					top_ofs = top_ofs + count[desa_pkg::OFFSET_BITS-1:0];
				end
			end
		endcase
		g.top_mark    = top_ofs[31:0];
		g.bottom_mark = bottom_ofs[31:0];
		return g;
	endfunction

	function automatic int draw_gap(bit on);
		return on ? int'($urandom_range(0, 12)) : 0;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %0h, want %0h", what, got, want);
		mismatches++;
	endtask

	task automatic push_req(desa_pkg::req_kind_t kind, logic [31:0] count, logic [3:0] align);
		desa_pkg::req_t r;
		r.req_type   = kind;
		r.byte_count = count;
		r.align_log2 = align;
		request_q.push_back(r);
		issued++;
	endtask

	task automatic push_random(int n);
		int                  sel;
		int                  lim;
		logic [31:0]         count;
		logic [3:0]          align;
		desa_pkg::req_kind_t kind;
		for (int i = 0; i < n; i++) begin
			lim = ((region_bytes >> 3) == 0) ? 1 : int'(region_bytes >> 3);
			sel = $urandom_range(0, 15);
			case (sel)
				0:       count = '0;
				1:       count = $urandom;
				2:       count = 32'hFFFF_FFFF - $urandom_range(0, 255);
				3:       count = region_bytes;
				default: count = $urandom_range(1, lim);
			endcase
			sel = $urandom_range(0, 9);
			if (sel < 3) begin
				kind = desa_pkg::REQ_ALLOC_BOTTOM;
			end else if (sel < 6) begin
				kind = desa_pkg::REQ_ALLOC_TOP;
			end else if (sel < 8) begin
				kind = desa_pkg::REQ_FREE_BOTTOM;
			end else begin
				kind = desa_pkg::REQ_FREE_TOP;
			end
			align = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
				4'($urandom_range(0, 5));
			push_req(kind, count, align);
		end
	endtask

	task automatic write_reg(desa_pkg::cfg_index_t idx, logic [63:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == desa_pkg::CFG_REGION_BASE) begin
			base_addr = value;
		end else begin
			region_bytes = value[31:0];
			top_ofs      = value[31:0];
			bottom_ofs   = '0;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (accepted != issued || grant_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk) begin : drive_requests
		desa_pkg::req_t r;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !req_acc) begin
		end else if (send_wait > 0) begin
			req_ch.valid <= 1'b0;
			send_wait--;
		end else if (request_q.size() > 0) begin
			r = request_q.pop_front();
			req_ch.req_type   <= r.req_type;
			req_ch.byte_count <= r.byte_count;
			req_ch.align_log2 <= r.align_log2;
			req_ch.valid      <= 1'b1;
			send_wait = draw_gap(send_idle);
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	always @(posedge clk) begin : take_requests
		desa_pkg::req_t r;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			r.req_type   = req_ch.req_type;
			r.byte_count = req_ch.byte_count;
			r.align_log2 = req_ch.align_log2;
			grant_q.push_back(next_grant(r));
			accepted++;
			req_acc = 1'b1;
		end else begin
			req_acc = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (hold_request) begin
				long_hold    = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (long_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				long_hold--;
			end else if (rsp_wait > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_wait--;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		desa_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_acc  = 1'b1;
			rsp_wait = draw_gap(recv_idle);
			if (grant_q.size() == 0) begin
				report_mismatch("unrequested result", rsp_ch.address, '0);
			end else begin
				want = grant_q.pop_front();
				if (rsp_ch.status !== want.status) begin
					report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
				end
				if (rsp_ch.address !== want.address) begin
					report_mismatch("address", rsp_ch.address, want.address);
				end
				if (rsp_ch.top_mark !== want.top_mark) begin
					report_mismatch("top_mark", 64'(rsp_ch.top_mark), 64'(want.top_mark));
				end
				if (rsp_ch.bottom_mark !== want.bottom_mark) begin
					report_mismatch("bottom_mark", 64'(rsp_ch.bottom_mark),
						64'(want.bottom_mark));
				end
			end
		end else begin
			rsp_acc = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (req_acc || rsp_acc) begin
				stuck = 0;
			end else begin
				stuck++;
			end
			if (stuck >= STUCK_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = desa_pkg::CFG_REGION_BASE;
		cfg_data          = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = '0;
		req_ch.byte_count = '0;
		req_ch.align_log2 = '0;
		rsp_ch.ready      = 1'b0;
		base_addr         = '0;
		region_bytes      = desa_pkg::REGION_SIZE_RESET;
		top_ofs           = desa_pkg::REGION_SIZE_RESET;
		bottom_ofs        = '0;
		issued            = 0;
		accepted          = 0;
		mismatches        = 0;
		stuck             = 0;
		send_wait         = 0;
		rsp_wait          = 0;
		long_hold         = 0;
		send_idle         = 1'b0;
		recv_idle         = 1'b0;
		hold_request      = 1'b0;
		req_acc           = 1'b0;
		rsp_acc           = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		push_req(desa_pkg::REQ_ALLOC_BOTTOM, 32'd0, 4'd0);
		push_req(desa_pkg::REQ_ALLOC_TOP, 32'd0, 4'd15);
		push_req(desa_pkg::REQ_ALLOC_BOTTOM, 32'd100, 4'd0);
		push_req(desa_pkg::REQ_ALLOC_BOTTOM, 32'd1, 4'd4);
		push_req(desa_pkg::REQ_ALLOC_TOP, 32'd100, 4'd3);
		push_req(desa_pkg::REQ_ALLOC_TOP, 32'hFFFF_FFFF, 4'd0);
		push_req(desa_pkg::REQ_ALLOC_BOTTOM, 32'hFFFF_FFFF, 4'd15);
		push_req(desa_pkg::REQ_FREE_BOTTOM, 32'd0, 4'd0);
		push_req(desa_pkg::REQ_FREE_TOP, 32'hFFFF_FFFF, 4'd0);
		wait_drained();

		write_reg(desa_pkg::CFG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(desa_pkg::CFG_REGION_SIZE, {32'hFFFF_FFFF, 32'd256});
		push_req(desa_pkg::REQ_ALLOC_BOTTOM, 32'd256, 4'd0);
		push_req(desa_pkg::REQ_ALLOC_BOTTOM, 32'd255, 4'd0);
		push_req(desa_pkg::REQ_ALLOC_TOP, 32'd1, 4'd0);
		push_req(desa_pkg::REQ_FREE_BOTTOM, 32'd300, 4'd0);
		push_req(desa_pkg::REQ_ALLOC_TOP, 32'd256, 4'd0);
		push_req(desa_pkg::REQ_ALLOC_TOP, 32'd255, 4'd0);
		push_req(desa_pkg::REQ_FREE_TOP, 32'hFFFF_FFFF, 4'd0);
		push_req(desa_pkg::REQ_FREE_TOP, 32'd0, 4'd0);
		push_req(desa_pkg::REQ_ALLOC_TOP, 32'd16, 4'd15);
		push_req(desa_pkg::REQ_ALLOC_BOTTOM, 32'd16, 4'd15);
		push_req(desa_pkg::REQ_FREE_BOTTOM, 32'd0, 4'd0);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0:       write_reg(desa_pkg::CFG_REGION_BASE, '0);
				1:       write_reg(desa_pkg::CFG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
				default: write_reg(desa_pkg::CFG_REGION_BASE, {$urandom, $urandom});
			endcase
			case (p)
				0:       write_reg(desa_pkg::CFG_REGION_SIZE, {$urandom, 32'd0});
				1:       write_reg(desa_pkg::CFG_REGION_SIZE, {$urandom, 32'hFFFF_FFFF});
				2:       write_reg(desa_pkg::CFG_REGION_SIZE,
					{32'd0, 32'($urandom_range(16, 1024))});
				5:       write_reg(desa_pkg::CFG_REGION_SIZE, {$urandom, $urandom});
				default: write_reg(desa_pkg::CFG_REGION_SIZE,
					{$urandom, 32'($urandom_range(64, 65536))});
			endcase
			send_idle = (p % 3 != 1);
			recv_idle = (p % 4 != 2);
			if (p == 3) begin
				send_idle    = 1'b0;
				hold_request = 1'b1;
			end
			push_random((p == 0) ? 15 : 55);
			wait_drained();
		end

		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
